// ===== rtl/ctw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_pkg
// Shared types, codes and constants of the crank trigger wheel decoder.
// ----------------------------------------------------------------------------
package ctw_pkg;

  localparam int PositionCountDef = 8;
  localparam int TimeoutLimitDef  = 30;

  localparam int TicksW  = 24;
  localparam int CapsW   = 8;
  localparam int RpmW    = 14;
  localparam int AccW    = 32;
  localparam int PeriodW = 24;
  localparam int PerFullW = 32;   // ticks times microseconds per tick
  localparam int DivNW   = 34;    // dividend width of the shared divider
  localparam int SmpW    = 24;    // acceleration sample, signed
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 9;

  localparam int PosB1 = 2;
  localparam int PosB2 = 3;
  localparam int PosC1 = 4;

  localparam logic [PerFullW-1:0] MinPeriodUs = 32'd6000;
  localparam logic [RpmW-1:0]     MinRpm      = 14'd100;
  localparam logic [RpmW-1:0]     MaxRpm      = 14'd10000;
  localparam logic [DivNW-1:0]    RpmNumer    = 34'd60000000;
  localparam logic [19:0]         UsPerSec    = 20'd1000000;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgRatioMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRatioMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCisOn    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCisOff   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCoeff    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTickUs   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgKeyBegin = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgKeyEnd   = 3'd7;

  // status flag bits
  localparam int FlPos = 0;
  localparam int FlPer = 1;
  localparam int FlRpm = 2;
  localparam int FlAcc = 3;
  localparam int FlSs  = 4;

  // command codes
  localparam logic [1:0] SensNone     = 2'd0;
  localparam logic [1:0] SensKeyBegin = 2'd1;
  localparam logic [1:0] SensKeyEnd   = 2'd2;
  localparam logic [1:0] SensInvert   = 2'd3;
  localparam logic [4:0] TmrNone      = 5'd0;
  localparam logic [4:0] TmrStart     = 5'd1;
  localparam logic [4:0] TmrReset     = 5'd2;
  localparam logic [4:0] TmrContOn    = 5'd4;
  localparam logic [4:0] TmrContOff   = 5'd8;
  localparam logic [4:0] TmrStop      = 5'd16;
  localparam logic [1:0] CisNone      = 2'd0;
  localparam logic [1:0] CisEnable    = 2'd1;
  localparam logic [1:0] CisDisable   = 2'd2;

  typedef enum logic [5:0] {
    SY_INIT    = 6'b000001,
    SY_ASYNC   = 6'b000010,
    SY_KEY     = 6'b000100,
    SY_GAP     = 6'b001000,
    SY_SYNC    = 6'b010000,
    SY_TIMEOUT = 6'b100000
  } sync_e;

  typedef enum logic [11:0] {
    C_IDLE   = 12'b000000000001,
    C_CALC   = 12'b000000000010,
    C_BRANCH = 12'b000000000100,
    C_RDIV   = 12'b000000001000,
    C_RCHK   = 12'b000000010000,
    C_RDEC   = 12'b000000100000,
    C_MULD   = 12'b000001000000,
    C_ADST   = 12'b000010000000,
    C_ADIV   = 12'b000100000000,
    C_EMA1   = 12'b001000000000,
    C_EMA2   = 12'b010000000000,
    C_COMMIT = 12'b100000000000
  } ctrl_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_rpm;
    logic take_rpm;
    logic mul_delta;
    logic div_acc;
    logic mul_ema;
    logic ema_fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_acc;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ctw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_in_if / ctw_out_if
// Valid/ready channels carrying decoder input items and result items.
// ----------------------------------------------------------------------------
interface ctw_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] cur_ticks;
  logic [23:0] prev_ticks;
  logic [23:0] prev2_ticks;
  logic [7:0]  captures_since_reset;
  modport source (output valid, req_type, cur_ticks, prev_ticks, prev2_ticks,
                  captures_since_reset, input ready);
  modport sink (input valid, req_type, cur_ticks, prev_ticks, prev2_ticks,
                captures_since_reset, output ready);
endinterface

interface ctw_out_if #(parameter int PosW = 4);
  logic               valid;
  logic               ready;
  logic [PosW-1:0]    crank_pos;
  logic [1:0]         engine_phase;
  logic [4:0]         status_flags;
  logic [23:0]        period_val;
  logic [13:0]        rpm_value;
  logic signed [31:0] accel_rpm_s;
  logic [1:0]         sensing_cmd;
  logic [4:0]         timer_cmd;
  logic [1:0]         cis_cmd;
  logic               update_irq;
  logic               sync_lost;
  modport source (output valid, crank_pos, engine_phase, status_flags, period_val,
                  rpm_value, accel_rpm_s, sensing_cmd, timer_cmd, cis_cmd,
                  update_irq, sync_lost, input ready);
  modport sink (input valid, crank_pos, engine_phase, status_flags, period_val,
                rpm_value, accel_rpm_s, sensing_cmd, timer_cmd, cis_cmd,
                update_irq, sync_lost, output ready);
endinterface

// ===== rtl/ctw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctw_div
  import ctw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivNW-1:0]    dividend_i,
  input  logic [PerFullW-1:0] divisor_i,
  output logic                done_o,
  output logic [DivNW-1:0]    quot_o
);
  localparam int CntW = $clog2(DivNW + 1);

  logic                busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [PerFullW-1:0] rem_q, dsr_q;
  logic [DivNW-1:0]    quo_q;
  logic [PerFullW:0]   trial;
  logic                fits;

  assign trial  = {rem_q, quo_q[DivNW-1]};
  assign fits   = trial >= {1'b0, dsr_q};
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivNW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? PerFullW'(trial - {1'b0, dsr_q}) : trial[PerFullW-1:0];
      quo_q <= {quo_q[DivNW-2:0], fits};
    end
  end

endmodule

// ===== rtl/ctw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_ctrl
// Sequencer: steps one item through check, division, filter and commit.
// ----------------------------------------------------------------------------
module ctw_ctrl
  import ctw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  ctrl_e st_q, st_d;

  assign in_ready_o = (st_q == C_IDLE);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      C_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = C_CALC;
        end
      end
      C_CALC: begin
        cmd_o.calc = 1'b1;
        st_d = C_BRANCH;
      end
      C_BRANCH: begin
        if (sts_i.need_div) begin
          cmd_o.div_rpm = 1'b1;
          st_d = C_RDIV;
        end else begin
          st_d = C_COMMIT;
        end
      end
      C_RDIV: if (sts_i.div_done) st_d = C_RCHK;
      C_RCHK: begin
        cmd_o.take_rpm = 1'b1;
        st_d = C_RDEC;
      end
      C_RDEC: st_d = sts_i.need_acc ? C_MULD : C_COMMIT;
      C_MULD: begin
        cmd_o.mul_delta = 1'b1;
        st_d = C_ADST;
      end
      C_ADST: begin
        cmd_o.div_acc = 1'b1;
        st_d = C_ADIV;
      end
      C_ADIV: if (sts_i.div_done) st_d = C_EMA1;
      C_EMA1: begin
        cmd_o.mul_ema = 1'b1;
        st_d = C_EMA2;
      end
      C_EMA2: begin
        cmd_o.ema_fin = 1'b1;
        st_d = C_COMMIT;
      end
      C_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          st_d = C_IDLE;
        end
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= C_IDLE;
    else         st_q <= st_d;
  end

endmodule

// ===== rtl/ctw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_dp
// Datapath: registers, sync states, ratio check, timing arithmetic, result.
// ----------------------------------------------------------------------------
module ctw_dp
  import ctw_pkg::*;
#(
  parameter int PositionCount = PositionCountDef,
  parameter int TimeoutLimit  = TimeoutLimitDef,
  parameter int PosW          = $clog2(PositionCount + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  ctw_in_if.sink             in_if,
  ctw_out_if.source          out_if,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);
  localparam int TmoW = $clog2(TimeoutLimit + 1);
  localparam logic [PosW-1:0] PosUndef = PosW'(PositionCount);
  localparam logic [PosW-1:0] PosLast  = PosW'(PositionCount - 1);

  // configuration
  logic [6:0] rmin_q, rmax_q;
  logic [2:0] cis_on_q, cis_off_q;
  logic [8:0] coeff_q;
  logic [7:0] tick_q;

  // decoder state
  sync_e              sy_q, sy_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [1:0]         ph_q, ph_d;
  logic [4:0]         fl_q, fl_d;
  logic               cont_q, cont_d;
  logic [RpmW-1:0]    lrpm_q, lrpm_d;
  logic signed [AccW-1:0] lacc_q, lacc_d;
  logic [TmoW-1:0]    tmo_q, tmo_d;
  logic [PeriodW-1:0] per_q, per_d;
  logic [RpmW-1:0]    rpm_q, rpm_d;

  // captured item and intermediate results
  logic              req_q;
  logic [TicksW-1:0] cur_q, prv_q, prv2_q;
  logic [CapsW-1:0]  caps_q;
  logic              rok_q;
  logic [PerFullW-1:0] pfull_q;
  logic [DivNW-1:0]  rpmf_q;
  logic              dneg_q;
  logic [DivNW-1:0]  dprod_q;
  logic signed [33:0] p1_q;
  logic signed [41:0] p2_q;
  logic signed [AccW-1:0] acc_q;

  // result register
  logic out_vld_q;

  // divider
  logic             div_start, div_done;
  logic [DivNW-1:0] div_n, div_q;

  ctw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (pfull_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign div_start = cmd_i.div_rpm || cmd_i.div_acc;
  assign div_n     = cmd_i.div_rpm ? RpmNumer : dprod_q;

  // ratio check operands
  logic              gap;
  logic [TicksW:0]   den;
  logic [TicksW-1:0] numx, sync_iv, key_iv;
  logic [30:0]       num;
  logic [31:0]       lo;
  logic [32:0]       hi;
  logic              pre, rat;

  always_comb begin
    gap     = (sy_q == SY_GAP);
    sync_iv = (cur_q > prv2_q) ? cur_q - prv2_q : '0;
    key_iv  = (prv_q > prv2_q) ? prv_q - prv2_q : '0;
    den     = gap ? ({1'b0, prv_q} + {1'b0, cur_q}) : {1'b0, sync_iv};
    numx    = gap ? prv_q : key_iv;
    num     = 31'(numx * 7'd100);
    lo      = 32'(rmin_q * den);
    hi      = 33'(({1'b0, rmax_q} + 8'd1) * den);
    rat     = (den != '0) && ({2'b0, num} >= {1'b0, lo}) && ({2'b0, num} < hi);
    if (gap)
      pre = (cur_q != '0) && (prv_q != '0) && (caps_q == CapsW'(1)) && !cont_q;
    else
      pre = (cur_q != '0) && (prv_q != '0) && (prv2_q != '0) &&
            (caps_q >= CapsW'(7)) && cont_q;
  end

  // next crank position and timing preconditions
  logic [PosW-1:0] pos_nx;
  logic            tpre, rpm_ok, lrpm_in;

  always_comb begin
    if (pos_q < PosUndef) pos_nx = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
    else                  pos_nx = PosUndef;
    tpre    = cont_q && (caps_q == CapsW'(1)) && (prv_q != '0) && (prv2_q != '0);
    rpm_ok  = (rpmf_q >= DivNW'(MinRpm)) && (rpmf_q <= DivNW'(MaxRpm));
    lrpm_in = (lrpm_q > MinRpm) && (lrpm_q < MaxRpm);
  end

  assign sts_o.need_div = !req_q && (sy_q == SY_SYNC) && (pos_nx == PosW'(PosB2)) &&
                          tpre && (pfull_q >= MinPeriodUs);
  assign sts_o.need_acc = rpm_ok && lrpm_in;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_vld_q || out_if.ready;

  // filter arithmetic
  logic [8:0]  a_eff;
  logic signed [RpmW:0] delta;
  logic [RpmW-1:0] dmag;
  logic signed [SmpW-1:0] smp;
  logic signed [42:0] sum, nsum;
  logic [42:0] mag;
  logic signed [AccW-1:0] acc_n;

  always_comb begin
    a_eff = (coeff_q > 9'd256) ? 9'd256 : coeff_q;
    delta = $signed({1'b0, rpmf_q[RpmW-1:0]}) - $signed({1'b0, lrpm_q});
    dmag  = delta[RpmW] ? RpmW'(-delta) : delta[RpmW-1:0];
    smp   = dneg_q ? -$signed(div_q[SmpW-1:0]) : $signed(div_q[SmpW-1:0]);
    sum   = 43'(p1_q) + 43'(p2_q);
    nsum  = -sum;
    mag   = (sum[42] ? nsum : sum) + 43'd128;
    mag   = mag >> 8;
    if (sum[42])
      acc_n = (mag > 43'h0_8000_0000) ? $signed(32'h8000_0000) : -$signed(mag[31:0]);
    else
      acc_n = (mag > 43'h0_7FFF_FFFF) ? $signed(32'h7FFF_FFFF) : $signed(mag[31:0]);
  end

  // state update for one item
  logic [1:0] sens_c, cis_c;
  logic [4:0] tmr_c;
  logic       irq_c, lost_c, clr_int;

  always_comb begin
    sy_d = sy_q;  pos_d = pos_q;  ph_d = ph_q;  fl_d = fl_q;  cont_d = cont_q;
    lrpm_d = lrpm_q;  lacc_d = lacc_q;  tmo_d = tmo_q;  per_d = per_q;  rpm_d = rpm_q;
    sens_c = SensNone;  tmr_c = TmrNone;  cis_c = CisNone;
    irq_c = 1'b0;  lost_c = 1'b0;  clr_int = 1'b0;
    if (req_q) begin
      sy_d = SY_TIMEOUT;
      clr_int = 1'b1;
      if (tmo_q >= TmoW'(TimeoutLimit)) begin
        tmr_c  = TmrStop;
        cont_d = 1'b0;
      end else begin
        tmo_d = tmo_q + TmoW'(1);
      end
    end else begin
      fl_d[FlSs] = 1'b0;
      tmo_d = '0;
      unique case (sy_q)
        SY_ASYNC: begin
          sens_c = SensKeyEnd;
          sy_d   = SY_KEY;
        end
        SY_KEY: begin
          sens_c = SensKeyBegin;
          sy_d   = SY_GAP;
        end
        SY_GAP: begin
          sens_c = SensKeyEnd;
          if (rok_q) begin
            sy_d   = SY_SYNC;
            pos_d  = PosW'(PosB1);
            tmr_c  = TmrReset | TmrContOn;
            cont_d = 1'b1;
          end else begin
            sy_d    = SY_KEY;
            tmr_c   = TmrContOff;
            cont_d  = 1'b0;
            clr_int = 1'b1;
          end
        end
        SY_SYNC: begin
          pos_d  = pos_nx;
          sens_c = SensInvert;
          if (pos_nx == PosW'(PosB1)) begin
            if (rok_q) begin
              fl_d[FlPos] = 1'b1;
              tmr_c = TmrReset;
            end else begin
              clr_int = 1'b1;
              sy_d    = SY_INIT;
              lost_c  = 1'b1;
            end
          end else if (pos_nx == PosW'(PosB2)) begin
            fl_d[FlPer] = 1'b0;  fl_d[FlRpm] = 1'b0;  fl_d[FlAcc] = 1'b0;
            per_d = '0;  rpm_d = '0;
            if (tpre) begin
              if (pfull_q < MinPeriodUs || !rpm_ok) begin
                lrpm_d = '0;
                lacc_d = '0;
              end else begin
                per_d = pfull_q[PeriodW-1:0];
                rpm_d = rpmf_q[RpmW-1:0];
                fl_d[FlPer] = 1'b1;  fl_d[FlRpm] = 1'b1;  fl_d[FlSs] = 1'b0;
                if (lrpm_in) begin
                  lacc_d = acc_q;
                  fl_d[FlAcc] = 1'b1;
                end
                lrpm_d = rpmf_q[RpmW-1:0];
              end
            end
          end else if (pos_nx == PosW'(PosC1)) begin
            if (ph_q == 2'd1)      ph_d = 2'd2;
            else if (ph_q == 2'd2) ph_d = 2'd1;
          end
          if (pos_nx == PosW'(cis_on_q))       cis_c = CisEnable;
          else if (pos_nx == PosW'(cis_off_q)) cis_c = CisDisable;
          if (!clr_int && fl_d[FlPos] && fl_d[FlPer] && fl_d[FlRpm]) irq_c = 1'b1;
        end
        SY_TIMEOUT: sy_d = SY_INIT;
        default: begin
          sy_d    = SY_ASYNC;
          sens_c  = SensKeyBegin;
          tmr_c   = TmrStart;
          cont_d  = 1'b0;
          clr_int = 1'b1;
        end
      endcase
    end
    if (clr_int) begin
      pos_d = PosUndef;  ph_d = 2'd0;
      fl_d[FlPos] = 1'b0;  fl_d[FlPer] = 1'b0;  fl_d[FlRpm] = 1'b0;  fl_d[FlAcc] = 1'b0;
      per_d = '0;  rpm_d = '0;  lrpm_d = '0;  lacc_d = '0;
    end
    if (req_q) fl_d[FlSs] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= 7'd0;  rmax_q <= 7'd100;  cis_on_q <= 3'd0;  cis_off_q <= 3'd4;
      coeff_q <= 9'd256;  tick_q <= 8'd1;
      sy_q <= SY_INIT;  pos_q <= PosUndef;  ph_q <= 2'd0;
      fl_q <= 5'b1_0000;  cont_q <= 1'b0;  lrpm_q <= '0;  lacc_q <= '0;
      tmo_q <= '0;  per_q <= '0;  rpm_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRatioMin: rmin_q    <= cfg_wdata_i[6:0];
          CfgRatioMax: rmax_q    <= cfg_wdata_i[6:0];
          CfgCisOn:    cis_on_q  <= cfg_wdata_i[2:0];
          CfgCisOff:   cis_off_q <= cfg_wdata_i[2:0];
          CfgCoeff:    coeff_q   <= cfg_wdata_i;
          CfgTickUs:   tick_q    <= cfg_wdata_i[7:0];
          // pickup edge polarity registers are not stored by this block
          CfgKeyBegin, CfgKeyEnd: ;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        sy_q <= sy_d;  pos_q <= pos_d;  ph_q <= ph_d;  fl_q <= fl_d;  cont_q <= cont_d;
        lrpm_q <= lrpm_d;  lacc_q <= lacc_d;  tmo_q <= tmo_d;  per_q <= per_d;
        rpm_q <= rpm_d;
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_if.req_type;
      cur_q  <= in_if.cur_ticks;
      prv_q  <= in_if.prev_ticks;
      prv2_q <= in_if.prev2_ticks;
      caps_q <= in_if.captures_since_reset;
    end
    if (cmd_i.calc) begin
      rok_q   <= pre && rat;
      pfull_q <= 32'(cur_q * tick_q);
    end
    if (cmd_i.take_rpm) rpmf_q <= div_q;
    if (cmd_i.mul_delta) begin
      dneg_q  <= delta[RpmW];
      dprod_q <= DivNW'(dmag * UsPerSec);
    end
    if (cmd_i.mul_ema) begin
      p1_q <= 34'($signed({1'b0, a_eff}) * smp);
      p2_q <= 42'($signed(10'd256 - {1'b0, a_eff}) * lacc_q);
    end
    if (cmd_i.ema_fin) acc_q <= acc_n;
    if (cmd_i.commit) begin
      out_if.crank_pos    <= pos_d;
      out_if.engine_phase <= ph_d;
      out_if.status_flags <= fl_d;
      out_if.period_val   <= per_d;
      out_if.rpm_value    <= rpm_d;
      out_if.accel_rpm_s  <= fl_d[FlAcc] ? lacc_d : '0;
      out_if.sensing_cmd  <= sens_c;
      out_if.timer_cmd    <= tmr_c;
      out_if.cis_cmd      <= cis_c;
      out_if.update_irq   <= irq_c;
      out_if.sync_lost    <= lost_c;
    end
  end

  assign out_if.valid = out_vld_q;

endmodule

// ===== rtl/crank_trigger_wheel_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crank_trigger_wheel_decoder_unit
// Crank trigger wheel sync decoder: sync states, crank position, phase,
// period, rpm and filtered acceleration, with sensing/timer/CIS commands.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      carries
//  in_if    sink       valid/ready    pickup edge or timeout event, timer ticks
//  out_if   source     valid/ready    position, phase, flags, timing, commands
//  cfg      write      cfg_we_i       eight register indexes, six stored, no read-back
//
//  An item goes through load, check and commit; at B2 with a valid period
//  it also takes one 34-bit rpm division, and when acceleration is also
//  filtered a second division on the shared bit-serial divider.
//  Reset clears all decoder state at once; no clearing pass.
//  A result waits in the output register; the next item is taken meanwhile
//  and held before commit until that result has been taken.
// ----------------------------------------------------------------------------
module crank_trigger_wheel_decoder_unit
  import ctw_pkg::*;
#(
  parameter int PositionCount = PositionCountDef,
  parameter int TimeoutLimit  = TimeoutLimitDef,
  parameter int PosW          = $clog2(PositionCount + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  ctw_in_if.sink             in_if,
  ctw_out_if.source          out_if
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: accept, check, divide, filter, commit
  ctw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_if.ready = in_ready;

  // all decoder state, arithmetic and the result register
  ctw_dp #(
    .PositionCount (PositionCount),
    .TimeoutLimit  (TimeoutLimit),
    .PosW          (PosW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
